// ----- sv/stp_pkg.sv -----
// Package for the string-to-integer parser: constants, codes, phase type, digit decode.
`default_nettype none
package stp_pkg;

  localparam int WORD_BITS_DEF     = 64;
  localparam int POSITION_BITS_DEF = 16;

  localparam int VALUE_BITS     = 64;
  localparam int INDEX_BITS     = 16;
  localparam int CHAR_BITS      = 8;
  localparam int BASE_BITS      = 6;
  localparam int CFG_DATA_BITS  = 6;
  localparam int CFG_INDEX_BITS = 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BASE_SELECT = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } cfg_reg_t;

  typedef enum logic [5:0] {
    PH_SPACE    = 6'b000001,
    PH_START    = 6'b000010,
    PH_ZERO     = 6'b000100,
    PH_HEXFIRST = 6'b001000,
    PH_DIGITS   = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_t;

  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_LO_Z  = 8'h7A;

  localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_BITS-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_BITS-1:0] DIGIT_NONE = 6'd63;
  localparam logic [BASE_BITS-1:0] LETTER_OFS = 6'd10;

  // Digit value of a byte; letters of either case map to 10..35.
  function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] t;
    logic [BASE_BITS-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      d = t[BASE_BITS-1:0];
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      t = c - CH_LO_A;
      d = t[BASE_BITS-1:0] + LETTER_OFS;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      t = c - CH_UP_A;
      d = t[BASE_BITS-1:0] + LETTER_OFS;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- sv/stp_if.sv -----
// Stream interfaces: byte input channel and parse result channel.
`default_nettype none
interface stp_char_if;
  logic                           valid;
  logic                           ready;
  logic [stp_pkg::CHAR_BITS-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface stp_result_if;
  logic                            valid;
  logic                            ready;
  logic [stp_pkg::VALUE_BITS-1:0]  value;
  logic                            out_of_range;
  logic                            converted;
  logic [stp_pkg::INDEX_BITS-1:0]  end_index;

  modport source (output valid, output value, output out_of_range, output converted,
                  output end_index, input ready);
  modport sink   (input valid, input value, input out_of_range, input converted,
                  input end_index, output ready);
endinterface
`default_nettype wire

// ----- sv/stp_accum.sv -----
// Multiply-accumulate of one digit with limit check against the saturation bound.
`default_nettype none
module stp_accum #(
  parameter int WORD_BITS = stp_pkg::WORD_BITS_DEF
) (
  input  wire logic [WORD_BITS-1:0]          acc,
  input  wire logic [stp_pkg::BASE_BITS-1:0] base,
  input  wire logic [stp_pkg::BASE_BITS-1:0] digit,
  input  wire logic                          signed_mode,
  input  wire logic                          negative,
  output logic      [WORD_BITS-1:0]          acc_next,
  output logic                               over
);
  localparam int EXT_BITS = WORD_BITS + stp_pkg::BASE_BITS;
  localparam logic [WORD_BITS-1:0] SIGN_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic [WORD_BITS-1:0] limit;
  logic [EXT_BITS-1:0]  prod;
  logic [EXT_BITS-1:0]  sum;

  // acc*base+d > limit is the same test as the cutoff/cutlim pair, no divide.
  always_comb begin
    if (!signed_mode) limit = '1;
    else if (negative) limit = SIGN_BIT;
    else limit = SIGN_BIT - WORD_BITS'(1);
    prod     = EXT_BITS'(acc) * EXT_BITS'(base);
    sum      = prod + EXT_BITS'(digit);
    over     = sum > EXT_BITS'(limit);
    acc_next = sum[WORD_BITS-1:0];
  end
endmodule
`default_nettype wire

// ----- sv/string_to_integer_parser_top.sv -----
// Top level of the streaming string-to-integer parser.
//
//  channel   dir  beat payload                                   handshake
//  chars     in   char_code[7:0]                                 valid/ready
//  results   out  value[63:0] out_of_range converted end_index   valid/ready
//  cfg       in   cfg_index, cfg_data[5:0]                       cfg_write_en
//
// One byte per cycle sustained. A byte is held in the input register, is parsed
// there against the parse state, and a zero byte then loads the result register.
// The 64x6 digit multiply-add and its limit compare set the cycle time.
// Synchronous reset sets config to its defaults and clears parse state. A zero
// byte waits in the input register only while the result register holds a beat
// not yet taken; other bytes never wait.
`default_nettype none
module string_to_integer_parser_top #(
  parameter int WORD_BITS     = stp_pkg::WORD_BITS_DEF,
  parameter int POSITION_BITS = stp_pkg::POSITION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  stp_char_if.sink                                 chars,
  stp_result_if.source                             results,
  input  wire logic                                cfg_write_en,
  input  wire logic [stp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [stp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  localparam logic [WORD_BITS-1:0] SIGN_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

  // configuration
  logic [stp_pkg::BASE_BITS-1:0] base_select;
  logic                          signed_mode;

  // input register
  logic                          s1_valid;
  logic [stp_pkg::CHAR_BITS-1:0] s1_char;
  logic                          s1_fire;
  logic                          s1_nul;

  // parse state
  stp_pkg::phase_t               phase, phase_next;
  logic [stp_pkg::BASE_BITS-1:0] active_base, active_base_next;
  logic                          is_negative, is_negative_next;
  logic [WORD_BITS-1:0]          accumulator, accumulator_next;
  logic                          overflowed, overflowed_next;
  logic                          any_digit, any_digit_next;
  logic [POSITION_BITS-1:0]      byte_position, byte_position_next;
  logic [POSITION_BITS-1:0]      end_position, end_position_next;

  // digit path
  logic [stp_pkg::BASE_BITS-1:0] digit;
  logic [stp_pkg::BASE_BITS-1:0] start_base;
  logic [stp_pkg::BASE_BITS-1:0] digit_base;
  logic                          digit_ok;
  logic [WORD_BITS-1:0]          acc_sum;
  logic                          acc_over;
  logic [POSITION_BITS-1:0]      pos_inc;

  // result
  logic                          out_valid;
  logic [WORD_BITS-1:0]          res_word;
  logic [31:0]                   end_wide;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      base_select <= stp_pkg::BASE_AUTO;
      signed_mode <= 1'b1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        stp_pkg::REG_BASE_SELECT: base_select <= cfg_data;
        stp_pkg::REG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input register
  assign s1_nul      = (s1_char == stp_pkg::CH_NUL);
  // A non-zero byte only updates state; a zero byte needs the result slot.
  assign s1_fire     = s1_valid && (!s1_nul || !out_valid || results.ready);
  assign chars.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) s1_char <= chars.char_code;
  end

  // ---------------------------------------------------------------- digit path
  assign digit      = stp_pkg::digit_of(s1_char);
  assign start_base = (base_select == stp_pkg::BASE_AUTO) ? stp_pkg::BASE_DEC : base_select;
  // Before the number starts the base comes from config, afterwards from state.
  assign digit_base = (phase == stp_pkg::PH_SPACE || phase == stp_pkg::PH_START) ?
                      start_base : active_base;
  assign digit_ok   = (digit_base >= stp_pkg::BASE_MIN) && (digit_base <= stp_pkg::BASE_MAX)
                      && (digit < digit_base);
  assign pos_inc    = (byte_position == '1) ? byte_position
                                            : byte_position + POSITION_BITS'(1);

  stp_accum #(
    .WORD_BITS (WORD_BITS)
  ) u_accum (
    .acc         (accumulator),
    .base        (digit_base),
    .digit       (digit),
    .signed_mode (signed_mode),
    .negative    (is_negative),
    .acc_next    (acc_sum),
    .over        (acc_over)
  );

  // ---------------------------------------------------------------- parse step
  always_comb begin
    logic start;
    logic take;
    start              = 1'b0;
    take               = 1'b0;
    phase_next         = phase;
    active_base_next   = active_base;
    is_negative_next   = is_negative;
    accumulator_next   = accumulator;
    overflowed_next    = overflowed;
    any_digit_next     = any_digit;
    byte_position_next = byte_position;
    end_position_next  = end_position;

    if (s1_fire) begin
      if (s1_nul) begin
        // end of string: clear for the next one, config stays
        phase_next         = stp_pkg::PH_SPACE;
        active_base_next   = stp_pkg::BASE_AUTO;
        is_negative_next   = 1'b0;
        accumulator_next   = '0;
        overflowed_next    = 1'b0;
        any_digit_next     = 1'b0;
        byte_position_next = '0;
        end_position_next  = '0;
      end else begin
        byte_position_next = pos_inc;
        case (phase)
          stp_pkg::PH_SPACE: begin
            if (s1_char == stp_pkg::CH_SPACE ||
                (s1_char >= stp_pkg::CH_TAB && s1_char <= stp_pkg::CH_CR)) begin
            end else if (s1_char == stp_pkg::CH_PLUS || s1_char == stp_pkg::CH_MINUS) begin
              is_negative_next = (s1_char == stp_pkg::CH_MINUS);
              phase_next       = stp_pkg::PH_START;
            end else begin
              start = 1'b1;
            end
          end
          stp_pkg::PH_START: start = 1'b1;
          stp_pkg::PH_ZERO: begin
            if (s1_char == stp_pkg::CH_LO_X || s1_char == stp_pkg::CH_UP_X) begin
              active_base_next = stp_pkg::BASE_HEX;
              phase_next       = stp_pkg::PH_HEXFIRST;
            end else begin
              take = 1'b1;
            end
          end
          stp_pkg::PH_HEXFIRST, stp_pkg::PH_DIGITS: take = 1'b1;
          default: phase_next = stp_pkg::PH_DONE;
        endcase

        if (start) begin
          if (base_select == stp_pkg::BASE_ONE || base_select > stp_pkg::BASE_MAX) begin
            phase_next = stp_pkg::PH_DONE;
          end else if ((base_select == stp_pkg::BASE_AUTO || base_select == stp_pkg::BASE_HEX)
                       && s1_char == stp_pkg::CH_ZERO) begin
            // lone leading zero already counts as a digit
            active_base_next  = (base_select == stp_pkg::BASE_AUTO) ? stp_pkg::BASE_OCT
                                                                    : stp_pkg::BASE_HEX;
            any_digit_next    = 1'b1;
            end_position_next = pos_inc;
            phase_next        = stp_pkg::PH_ZERO;
          end else begin
            active_base_next = start_base;
            take             = 1'b1;
          end
        end

        if (take) begin
          if (digit_ok) begin
            any_digit_next    = 1'b1;
            end_position_next = pos_inc;
            phase_next        = stp_pkg::PH_DIGITS;
            if (!overflowed) begin
              if (acc_over) overflowed_next  = 1'b1;
              else          accumulator_next = acc_sum;
            end
          end else begin
            phase_next = stp_pkg::PH_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= stp_pkg::PH_SPACE;
      active_base   <= stp_pkg::BASE_AUTO;
      is_negative   <= 1'b0;
      accumulator   <= '0;
      overflowed    <= 1'b0;
      any_digit     <= 1'b0;
      byte_position <= '0;
      end_position  <= '0;
    end else begin
      phase         <= phase_next;
      active_base   <= active_base_next;
      is_negative   <= is_negative_next;
      accumulator   <= accumulator_next;
      overflowed    <= overflowed_next;
      any_digit     <= any_digit_next;
      byte_position <= byte_position_next;
      end_position  <= end_position_next;
    end
  end

  // ---------------------------------------------------------------- result register
  always_comb begin
    if (overflowed) begin
      if (!signed_mode)     res_word = '1;
      else if (is_negative) res_word = SIGN_BIT;
      else                  res_word = SIGN_BIT - WORD_BITS'(1);
    end else begin
      res_word = is_negative ? (WORD_BITS'(0) - accumulator) : accumulator;
    end
  end

  assign end_wide = 32'(end_position);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_nul) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_nul) begin
      // signed mode sign-extends from the word width, unsigned zero-extends
      results.value        <= signed_mode ? stp_pkg::VALUE_BITS'($signed(res_word))
                                          : stp_pkg::VALUE_BITS'(res_word);
      results.out_of_range <= overflowed;
      results.converted    <= any_digit;
      if (!any_digit)                results.end_index <= '0;
      else if (end_wide > 32'hFFFF)  results.end_index <= '1;
      else                           results.end_index <= end_wide[stp_pkg::INDEX_BITS-1:0];
    end
  end

  assign results.valid = out_valid;

endmodule
`default_nettype wire

// ----- sv/stp_checker.sv -----
// Port-level checker for the parser top level, with its bind statement.
`default_nettype none
module stp_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [stp_pkg::VALUE_BITS-1:0]   value,
  input wire logic                             out_of_range,
  input wire logic                             converted,
  input wire logic [stp_pkg::INDEX_BITS-1:0]   end_index
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(value))
    else $error("result value changed while stalled");

  a_no_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid && !converted |-> value == '0 && end_index == '0 && !out_of_range)
    else $error("result without digits is not empty");

  a_range_needs_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> converted && end_index != '0)
    else $error("saturated result without a digit");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind string_to_integer_parser_top stp_checker u_stp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .value        (results.value),
  .out_of_range (results.out_of_range),
  .converted    (results.converted),
  .end_index    (results.end_index)
);
`default_nettype wire
